// ----- design/assert_macros.svh -----
// assertion macros used by the filter design file
// no dependencies; each macro expects clk and rst_n in scope

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every rising clock edge out of reset
`define SSB_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same-cycle implication
`define SSB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ssb_pkg.sv -----
// types and constants for the slip/skid ball filter
// no dependencies

package ssb_pkg;

    // fixed-point widths
    localparam int ACCEL_W = 16;
    localparam int POS_W   = 24;
    localparam int WEIGHT_W = 16;
    localparam int MAG_W   = 16;
    localparam int SIGN_W  = 6;

    // divider: quotient bits produced one per cycle
    localparam int DIV_STEPS = 23;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // constants
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;
    localparam logic signed [16:0]  UNITY_Q12    = 17'sd4096;
    localparam logic [SIGN_W-1:0]   SIGN_PLUS    = 6'd43;
    localparam logic [SIGN_W-1:0]   SIGN_MINUS   = 6'd45;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [ACCEL_W-1:0]      load_t;

endpackage

// ----- design/slip_skid_ball_filter.sv -----
// slip/skid ball filter top level: divider, blend and output encoding
// depends on ssb_pkg and assert_macros.svh
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word of lateral_accel and
//   vertical_accel, both signed Q4.12 g. The load is the negated vertical
//   acceleration clamped to at least 1.0 g; the raw position is
//   10 * lateral / load, blended into the smoothed position with weight
//   smoothing_weight (Q0.16) written through cfg_wr_en/cfg_wr_data.
//   Output channel (out_valid/out_ready) gives ball_position (Q7.16), an
//   ASCII sign_code and magnitude_hundredths.
//   After input accept the word passes through the restoring divider, one
//   quotient bit per cycle through a single 17-bit subtract/compare, then
//   the difference, multiply, blend, absolute and scale states. One word is
//   in work at a time: no new word is taken until the sequencer is idle again.
//   in_ready is high only while the sequencer is idle. A new word may be
//   taken while the previous result still waits in the output register; if
//   the receiver stalls, the sequencer holds its result until the output
//   register is taken, then returns to idle.
//   Reset clears the smoothed position to zero and the weight to 6554.

`include "assert_macros.svh"

module slip_skid_ball_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [15:0] lateral_accel,
    input  logic signed [15:0] vertical_accel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [23:0] ball_position,
    output logic [5:0]  sign_code,
    output logic [15:0] magnitude_hundredths,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_BLEND = 3'd4;
    localparam logic [2:0] ST_ABS   = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [ssb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [15:0] weight_reg;
    ssb_pkg::pos_t smooth_reg, smooth_next;

    // datapath registers
    logic        neg_reg;
    ssb_pkg::load_t load_reg;
    logic [15:0] rem_reg;
    logic [22:0] low_reg;
    logic signed [24:0] diff_reg;
    logic signed [41:0] prod_reg;
    logic [23:0] abs_reg;

    // output register
    logic        out_valid_reg;
    ssb_pkg::pos_t pos_out_reg;
    logic [5:0]  sign_out_reg;
    logic [15:0] mag_out_reg;

    // input conditioning
    logic        in_fire;
    logic [15:0] lat_mag;
    logic [18:0] lat_mag10;
    logic signed [16:0] neg_vert;
    ssb_pkg::load_t load_in;

    // divider step
    logic [16:0] trial;
    logic        trial_ge;
    logic [15:0] rem_step;

    // blend and scale
    logic signed [23:0] raw_pos;
    logic signed [41:0] rounded;
    logic signed [25:0] blend_sum;
    logic [30:0] scaled;
    logic        out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // magnitude of lateral times ten, load clamped at one g
    always_comb
    begin
        lat_mag   = lateral_accel[15] ? 16'(-lateral_accel) : 16'(lateral_accel);
        lat_mag10 = ({3'b000, lat_mag} << 3) + ({3'b000, lat_mag} << 1);
        neg_vert  = -$signed({vertical_accel[15], vertical_accel});
        load_in   = (neg_vert < ssb_pkg::UNITY_Q12) ? 16'(ssb_pkg::UNITY_Q12)
                                                     : 16'(neg_vert);
    end

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, low_reg[22]};
        trial_ge = (trial >= {1'b0, load_reg});
        rem_step = trial_ge ? 16'(trial - {1'b0, load_reg}) : trial[15:0];
    end

    // blend arithmetic and hundredths scaling
    always_comb
    begin
        raw_pos   = neg_reg ? 24'(-{1'b0, low_reg}) : 24'({1'b0, low_reg});
        rounded   = prod_reg + 42'sd32768;
        blend_sum = {{2{smooth_reg[23]}}, smooth_reg} + rounded[41:16];
        scaled    = ({7'd0, abs_reg} << 6) + ({7'd0, abs_reg} << 5)
                  + ({7'd0, abs_reg} << 2);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        smooth_next = smooth_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ssb_pkg::DIV_CNT_W'(ssb_pkg::DIV_STEPS - 1))
                    state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_BLEND;
            ST_BLEND:
            begin
                smooth_next = blend_sum[23:0];
                state_next  = ST_ABS;
            end
            ST_ABS:   state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            weight_reg    <= ssb_pkg::WEIGHT_RESET;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            smooth_reg <= smooth_next;
            if (cfg_wr_en)
                weight_reg <= cfg_wr_data;
            if (state_reg == ST_SCALE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_reg  <= lateral_accel[15];
                    load_reg <= load_in;
                    rem_reg  <= {4'd0, lat_mag10[18:7]};
                    low_reg  <= {lat_mag10[6:0], 16'd0};
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_step;
                low_reg <= {low_reg[21:0], trial_ge};
            end
            ST_DIFF:
                diff_reg <= {raw_pos[23], raw_pos} - {smooth_reg[23], smooth_reg};
            ST_MUL:
                prod_reg <= diff_reg * $signed({1'b0, weight_reg});
            ST_ABS:
                abs_reg <= smooth_reg[23] ? 24'(-smooth_reg) : 24'(smooth_reg);
            ST_SCALE:
            begin
                // at most 8000, well under the 16-bit ceiling
                if (out_free)
                begin
                    pos_out_reg  <= smooth_reg;
                    sign_out_reg <= smooth_reg[23] ? ssb_pkg::SIGN_MINUS
                                                   : ssb_pkg::SIGN_PLUS;
                    mag_out_reg  <= {1'b0, scaled[30:16]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid            = out_valid_reg;
    assign ball_position        = pos_out_reg;
    assign sign_code            = sign_out_reg;
    assign magnitude_hundredths = mag_out_reg;

    // checks
    `SSB_ASSERT_IMPL(a_div_count, state_reg == ST_DIV,
        cnt_reg <= ssb_pkg::DIV_CNT_W'(ssb_pkg::DIV_STEPS - 1))
    `SSB_ASSERT_NEXT(a_accept_starts_div, in_fire, state_reg == ST_DIV)
    `SSB_ASSERT_IMPL(a_sign_matches, out_valid_reg,
        (sign_out_reg == ssb_pkg::SIGN_MINUS) == pos_out_reg[23])
    `SSB_ASSERT_IMPL(a_mag_range, out_valid_reg, mag_out_reg <= 16'd12800)

endmodule

// ----- bench/tb.sv -----
// testbench for slip_skid_ball_filter: directed, weight-extreme and random sample streams
// depends on ssb_pkg and the filter RTL; self-checking against an in-bench ball predictor
`timescale 1ns / 1ps

module tb;

    localparam longint Q16_ONE      = 65536;
    localparam longint Q16_HALF     = 32768;
    localparam longint HUNDREDTHS   = 100;
    localparam longint MAG_MAX      = 65535;
    localparam int     MAX_GAP      = 16;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     PHASE_WORDS  = 240;

    typedef struct {
        ssb_pkg::pos_t              pos;
        logic [ssb_pkg::SIGN_W-1:0] sign;
        logic [ssb_pkg::MAG_W-1:0]  mag;
    } ball_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic signed [15:0]  lateral_accel;
    logic signed [15:0]  vertical_accel;
    logic                out_valid;
    logic                out_ready;
    logic signed [23:0]  ball_position;
    logic [5:0]          sign_code;
    logic [15:0]         magnitude_hundredths;
    logic                cfg_wr_en;
    logic [15:0]         cfg_wr_data;

    // predictor state mirrors the block
    ssb_pkg::pos_t                filt_pos;
    logic [ssb_pkg::WEIGHT_W-1:0] weight_reg;
    ball_result_t                 ball_q[$];
    int                           fail_count;
    int                           idle_cycles;
    bit                           quiet;

    slip_skid_ball_filter u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .lateral_accel        (lateral_accel),
        .vertical_accel       (vertical_accel),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .ball_position        (ball_position),
        .sign_code            (sign_code),
        .magnitude_hundredths (magnitude_hundredths),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ball position, sign and hundredths for one sample; advances the filter
    function automatic ball_result_t predict_ball(input logic signed [15:0] lat,
                                                  input logic signed [15:0] vert);
        longint       load;
        longint       lat_mag;
        longint       quot;
        longint       raw;
        longint       blend;
        longint       next_pos;
        longint       abs_pos;
        longint       mag;
        ball_result_t r;
        load = -longint'(vert);
        if (load < longint'(ssb_pkg::UNITY_Q12))
            load = longint'(ssb_pkg::UNITY_Q12);
        lat_mag = (lat < 0) ? -longint'(lat) : longint'(lat);
        quot = (lat_mag * 10 * Q16_ONE) / load;
        raw = (lat < 0) ? -quot : quot;
        blend = longint'(weight_reg) * raw
              + (Q16_ONE - longint'(weight_reg)) * longint'(filt_pos) + Q16_HALF;
        next_pos = blend >>> 16;
        filt_pos = ssb_pkg::pos_t'(next_pos);
        abs_pos = (next_pos < 0) ? -next_pos : next_pos;
        mag = (abs_pos * HUNDREDTHS) / Q16_ONE;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        r.pos  = ssb_pkg::pos_t'(next_pos);
        r.sign = (next_pos < 0) ? ssb_pkg::SIGN_MINUS : ssb_pkg::SIGN_PLUS;
        r.mag  = mag[ssb_pkg::MAG_W-1:0];
        return r;
    endfunction

    // send one word and record its expected result on acceptance
    task automatic send_sample(input logic signed [15:0] lat, input logic signed [15:0] vert);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        lateral_accel  <= lat;
        vertical_accel <= vert;
        do @(posedge clk); while (!in_ready);
        ball_q.push_back(predict_ball(lat, vert));
    endtask

    // hold the sender until every expected word is back
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ball_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_weight(input logic [ssb_pkg::WEIGHT_W-1:0] w);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        weight_reg = w;
    endtask

    // mostly level-flight samples, some heavy, light or wild ones
    task automatic send_random_sample();
        logic signed [15:0] lat;
        logic signed [15:0] vert;
        int unsigned        kind;
        kind = $urandom_range(0, 9);
        lat  = 16'($urandom);
        vert = 16'($urandom);
        if (kind <= 5)
        begin
            lat  = 16'($signed($urandom_range(0, 8192)) - 4096);
            vert = 16'($signed($urandom_range(0, 2048)) - 5120);
        end
        else if (kind <= 7)
            vert = 16'(-$signed($urandom_range(4097, 32768)));
        else if (kind == 8)
            vert = 16'($signed($urandom_range(0, 36862)) - 4095);
        send_sample(lat, vert);
    endtask

    // field extremes, load clamp edges and upward acceleration at reset weight
    task automatic test_directed();
        logic signed [15:0] lat_set [18] = '{0, 32767, -32768, 32767, -32768, 1, -1, 4096,
                                             -2048, 32767, -32768, 12345, -12345, 32767, 0,
                                             -1, 21845, -21846};
        logic signed [15:0] vert_set [18] = '{-4096, -4096, -4096, -32768, -32768, -4096,
                                              -4096, -4096, -8192, 32767, 0, -4095, -4097,
                                              -1, 32767, -32768, -10923, 16384};
        quiet = 1'b1;
        for (int i = 0; i < 18; i++)
            send_sample(lat_set[i], vert_set[i]);
        quiet = 1'b0;
    endtask

    // largest, smallest and zero weight; zero must freeze the position
    task automatic test_weight_extremes();
        logic [ssb_pkg::WEIGHT_W-1:0] w_set [3] = '{16'hFFFF, 16'd1, 16'd0};
        for (int k = 0; k < 3; k++)
        begin
            set_weight(w_set[k]);
            for (int i = 0; i < 8; i++)
                send_random_sample();
        end
    endtask

    // random phases over several weights, with quiet stretches and pauses
    task automatic test_random();
        logic [ssb_pkg::WEIGHT_W-1:0] w_set [8] = '{ssb_pkg::WEIGHT_RESET, 16'hFFFF,
                                                    16'd1, 16'd32768, 16'd0, 16'hAAAA,
                                                    16'h5555, 16'd6554};
        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
                set_weight(16'($urandom_range(1, 65535)));
            else
                set_weight(w_set[p]);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if ($urandom_range(0, 63) == 0)
                    wait_results();
                if ($urandom_range(0, 99) == 0)
                    quiet = ~quiet;
                send_random_sample();
            end
        end
        quiet = 1'b0;
    endtask

    // receiver: random stall before each word
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        ball_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (ball_q.size() == 0)
            begin
                $error("unexpected result word: ball_position %0d", ball_position);
                fail_count++;
            end
            else
            begin
                exp_r = ball_q.pop_front();
                if (ball_position !== exp_r.pos)
                begin
                    $error("ball_position expected %0d actual %0d", exp_r.pos, ball_position);
                    fail_count++;
                end
                if (sign_code !== exp_r.sign)
                begin
                    $error("sign_code expected %0d actual %0d", exp_r.sign, sign_code);
                    fail_count++;
                end
                if (magnitude_hundredths !== exp_r.mag)
                begin
                    $error("magnitude_hundredths expected %0d actual %0d", exp_r.mag,
                           magnitude_hundredths);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        lateral_accel  = '0;
        vertical_accel = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        fail_count     = 0;
        idle_cycles    = 0;
        quiet          = 1'b0;
        filt_pos       = '0;
        weight_reg     = ssb_pkg::WEIGHT_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_weight_extremes();
        test_random();

        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
